FILE: rtl/c128_pkg.sv
// ----------------------------------------------------------------------------
// c128_pkg
// Shared types, substitution tables and level helpers for the auth hash.
// ----------------------------------------------------------------------------
`default_nettype none

package c128_pkg;

	localparam int NumRounds = 8;
	localparam int NumLevels = 5;
	localparam int NumBytes  = 16;
	localparam int PermMul   = 19;

	typedef logic [7:0] byte_t;
	typedef byte_t [NumBytes-1:0] vec16_t;
	typedef byte_t [2*NumBytes-1:0] vec32_t;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	localparam byte_t SBOX_A [256] = '{
		8'd197,8'd235,8'd60,8'd151,8'd98,8'd96,8'd3,8'd100,8'd248,8'd118,8'd42,8'd117,
		8'd172,8'd211,8'd181,8'd203,8'd61,8'd126,8'd156,8'd87,8'd149,8'd224,8'd55,8'd132,
		8'd186,8'd63,8'd238,8'd255,8'd85,8'd83,8'd152,8'd33,8'd160,8'd184,8'd210,8'd219,
		8'd159,8'd11,8'd180,8'd194,8'd130,8'd212,8'd147,8'd5,8'd215,8'd92,8'd27,8'd46,
		8'd113,8'd187,8'd52,8'd25,8'd185,8'd79,8'd221,8'd48,8'd70,8'd31,8'd101,8'd15,
		8'd195,8'd201,8'd50,8'd222,8'd137,8'd233,8'd229,8'd106,8'd122,8'd183,8'd178,8'd177,
		8'd144,8'd207,8'd234,8'd182,8'd37,8'd254,8'd227,8'd231,8'd54,8'd209,8'd133,8'd65,
		8'd202,8'd69,8'd237,8'd220,8'd189,8'd146,8'd120,8'd68,8'd21,8'd125,8'd38,8'd30,
		8'd2,8'd155,8'd53,8'd196,8'd174,8'd176,8'd51,8'd246,8'd167,8'd76,8'd110,8'd20,
		8'd82,8'd121,8'd103,8'd112,8'd56,8'd173,8'd49,8'd217,8'd252,8'd0,8'd114,8'd228,
		8'd123,8'd12,8'd93,8'd161,8'd253,8'd232,8'd240,8'd175,8'd67,8'd128,8'd22,8'd158,
		8'd89,8'd18,8'd77,8'd109,8'd190,8'd17,8'd62,8'd4,8'd153,8'd163,8'd59,8'd145,
		8'd138,8'd7,8'd74,8'd205,8'd10,8'd162,8'd80,8'd45,8'd104,8'd111,8'd150,8'd214,
		8'd154,8'd28,8'd191,8'd169,8'd213,8'd88,8'd193,8'd198,8'd200,8'd245,8'd39,8'd164,
		8'd124,8'd84,8'd78,8'd1,8'd188,8'd170,8'd23,8'd86,8'd226,8'd141,8'd32,8'd6,
		8'd131,8'd127,8'd199,8'd40,8'd135,8'd16,8'd57,8'd71,8'd91,8'd225,8'd168,8'd242,
		8'd206,8'd97,8'd166,8'd44,8'd14,8'd90,8'd236,8'd239,8'd230,8'd244,8'd223,8'd108,
		8'd102,8'd119,8'd148,8'd251,8'd29,8'd216,8'd8,8'd9,8'd249,8'd208,8'd24,8'd105,
		8'd94,8'd34,8'd64,8'd95,8'd115,8'd72,8'd134,8'd204,8'd43,8'd247,8'd243,8'd218,
		8'd47,8'd58,8'd73,8'd107,8'd241,8'd179,8'd116,8'd66,8'd36,8'd143,8'd81,8'd250,
		8'd139,8'd19,8'd13,8'd142,8'd140,8'd129,8'd192,8'd99,8'd171,8'd157,8'd136,8'd41,
		8'd75,8'd35,8'd165,8'd26
	};

	localparam byte_t SBOX_B [256] = '{
		8'd170,8'd42,8'd95,8'd141,8'd109,8'd30,8'd71,8'd89,8'd26,8'd147,8'd231,8'd205,
		8'd239,8'd212,8'd124,8'd129,8'd216,8'd79,8'd15,8'd185,8'd153,8'd14,8'd251,8'd162,
		8'd0,8'd241,8'd172,8'd197,8'd43,8'd10,8'd194,8'd235,8'd6,8'd20,8'd72,8'd45,
		8'd143,8'd104,8'd161,8'd119,8'd41,8'd136,8'd38,8'd189,8'd135,8'd25,8'd93,8'd18,
		8'd224,8'd171,8'd252,8'd195,8'd63,8'd19,8'd58,8'd165,8'd23,8'd55,8'd133,8'd254,
		8'd214,8'd144,8'd220,8'd178,8'd156,8'd52,8'd110,8'd225,8'd97,8'd183,8'd140,8'd39,
		8'd53,8'd88,8'd219,8'd167,8'd16,8'd198,8'd62,8'd222,8'd76,8'd139,8'd175,8'd94,
		8'd51,8'd134,8'd115,8'd22,8'd67,8'd1,8'd249,8'd217,8'd3,8'd5,8'd232,8'd138,
		8'd31,8'd56,8'd116,8'd163,8'd70,8'd128,8'd234,8'd132,8'd229,8'd184,8'd244,8'd13,
		8'd34,8'd73,8'd233,8'd154,8'd179,8'd131,8'd215,8'd236,8'd142,8'd223,8'd27,8'd57,
		8'd246,8'd108,8'd211,8'd8,8'd253,8'd85,8'd66,8'd245,8'd193,8'd78,8'd190,8'd4,
		8'd17,8'd7,8'd150,8'd127,8'd152,8'd213,8'd37,8'd186,8'd2,8'd243,8'd46,8'd169,
		8'd68,8'd101,8'd60,8'd174,8'd208,8'd158,8'd176,8'd69,8'd238,8'd191,8'd90,8'd83,
		8'd166,8'd125,8'd77,8'd59,8'd21,8'd92,8'd49,8'd151,8'd168,8'd99,8'd9,8'd50,
		8'd146,8'd113,8'd117,8'd228,8'd65,8'd230,8'd40,8'd82,8'd54,8'd237,8'd227,8'd102,
		8'd28,8'd36,8'd107,8'd24,8'd44,8'd126,8'd206,8'd201,8'd61,8'd114,8'd164,8'd207,
		8'd181,8'd29,8'd91,8'd64,8'd221,8'd255,8'd48,8'd155,8'd192,8'd111,8'd180,8'd210,
		8'd182,8'd247,8'd203,8'd148,8'd209,8'd98,8'd173,8'd11,8'd75,8'd123,8'd250,8'd118,
		8'd32,8'd47,8'd240,8'd202,8'd74,8'd177,8'd100,8'd80,8'd196,8'd33,8'd248,8'd86,
		8'd157,8'd137,8'd120,8'd130,8'd84,8'd204,8'd122,8'd81,8'd242,8'd188,8'd200,8'd149,
		8'd226,8'd218,8'd160,8'd187,8'd106,8'd35,8'd87,8'd105,8'd96,8'd145,8'd199,8'd159,
		8'd12,8'd121,8'd103,8'd112
	};

	// f(a, b) = A[B[a] ^ b]
	function automatic byte_t mixb(input byte_t a, input byte_t b);
		mixb = SBOX_A[SBOX_B[a] ^ b];
	endfunction

	// first half of a level: tmp[z] = f(w[z+16], w[z])
	function automatic vec16_t level_tmp(input vec32_t w);
		vec16_t t;
		for (int z = 0; z < NumBytes; z++) begin
			t[z] = mixb(w[z+NumBytes], w[z]);
		end
		level_tmp = t;
	endfunction

	// second half of a level: butterfly scatter
	function automatic vec32_t level_bfly(input vec32_t w, input vec16_t t, input int lvl);
		vec32_t r;
		int src;
		int hi;
		int lo;
		r = w;
		for (int j = 0; j < (1 << lvl); j++) begin
			for (int k = 0; k < (1 << (4 - lvl)); k++) begin
				src = ((k << lvl) + j) & 15;
				hi  = ((((2 * k) + 1) << lvl) + j) & 31;
				lo  = ((k << (lvl + 1)) + j) & 31;
				r[hi] = mixb(t[src], w[(src + 16) & 31]);
				r[lo] = t[src];
			end
		end
		level_bfly = r;
	endfunction

	// fixed bit permutation at the end of a round
	function automatic vec16_t perm(input vec32_t w);
		vec16_t s;
		int pos;
		int sh;
		for (int i = 0; i < NumBytes; i++) begin
			for (int j = 0; j < 8; j++) begin
				pos = ((PermMul * (j + 8 * i) + PermMul) & 255) / 8;
				sh  = (3 * j + 3) & 7;
				s[i][j] = w[pos][sh];
			end
		end
		perm = s;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/c128_if.sv
// ----------------------------------------------------------------------------
// c128_chal_if / c128_resp_if
// Valid/ready channels for challenge words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface c128_chal_if;
	logic        valid;
	logic        ready;
	logic [63:0] rand_high;
	logic [63:0] rand_low;
	modport source (output valid, rand_high, rand_low, input ready);
	modport sink   (input valid, rand_high, rand_low, output ready);
endinterface

interface c128_resp_if;
	logic        valid;
	logic        ready;
	logic [31:0] sres;
	logic [63:0] kc;
	modport source (output valid, sres, kc, input ready);
	modport sink   (input valid, sres, kc, output ready);
endinterface

`default_nettype wire

FILE: rtl/comp128_v3_auth_hash_top.sv
// ----------------------------------------------------------------------------
// comp128_v3_auth_hash_top
// COMP128 v3 style keyed hash: challenge in, signed response and cipher key out.
// ----------------------------------------------------------------------------
// One challenge word is taken every cycle unless the pipeline holds; its result
// word leaves the last of 81 register stages (one input stage and eight rounds
// of ten stages each, as every butterfly level is split into a table pass and a
// scatter pass). The whole pipeline advances together and holds when the result
// word is not taken; ready is high whenever the output stage is empty or being
// taken. The key is written over APB at byte addresses 0x0 (key_high) and 0x8
// (key_low); the user must do this only while idle; the block leaves that unchecked.
`default_nettype none

module comp128_v3_auth_hash_top
	import c128_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	c128_chal_if.sink        chal,
	c128_resp_if.source      resp
);

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	reg_idx_t    ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			unique case (ridx)
				REG_KEY_HIGH: key_high_q <= pwdata;
				REG_KEY_LOW:  key_low_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2:0] == 3'd0) begin
			unique case (ridx)
				REG_KEY_HIGH: prdata = key_high_q;
				REG_KEY_LOW:  prdata = key_low_q;
				default:      prdata = '0;
			endcase
		end
	end

	logic en;
	logic vld [NumRounds+1];
	vec16_t st  [NumRounds+1];
	vec16_t mix [NumRounds+1];

	assign en         = !resp.valid || resp.ready;
	assign chal.ready = en;

	// input stage: byte reversal and key mix
	vec16_t st_s1;
	vec16_t mix_s1;
	logic   vld_s1;
	logic [127:0] k128;
	logic [127:0] r128;
	assign k128 = {key_high_q, key_low_q};
	assign r128 = {chal.rand_high, chal.rand_low};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= chal.valid;
		end
	end

	// byte n of the reversed value is challenge byte 15-n, i.e. bits [8n+7:8n]
	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < NumBytes; n++) begin
				st_s1[n]  <= r128[8*n +: 8];
				mix_s1[n] <= r128[8*n +: 8] ^ k128[8*n +: 8];
			end
		end
	end

	assign vld[0] = vld_s1;
	assign st[0]  = st_s1;
	assign mix[0] = mix_s1;

	for (genvar r = 0; r < NumRounds; r++) begin : g_rnd
		c128_round u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (vld[r]),
			.st_in   (st[r]),
			.mix_in  (mix[r]),
			.vld_out (vld[r+1]),
			.st_out  (st[r+1]),
			.mix_out (mix[r+1])
		);
	end

	// result bytes are state bytes in reverse order, most significant first: sres from 15 to 12, kc from 7 to 0
	vec16_t fin;
	assign fin = st[NumRounds];

	assign resp.valid = vld[NumRounds];
	assign resp.sres  = {fin[15], fin[14], fin[13], fin[12]};
	assign resp.kc    = {fin[7], fin[6], fin[5], fin[4], fin[3], fin[2], fin[1], fin[0]};

endmodule

`default_nettype wire

FILE: rtl/c128_half.sv
// ----------------------------------------------------------------------------
// c128_half
// One pipeline stage: half of a butterfly level (table pass or scatter pass).
// ----------------------------------------------------------------------------
`default_nettype none

module c128_half
	import c128_pkg::*;
#(
	parameter int LVL     = 0,
	parameter bit SCATTER = 1'b0
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   vld_in,
	input  wire vec32_t w_in,
	input  wire vec16_t t_in,
	output logic        vld_s1,
	output vec32_t      w_s1,
	output vec16_t      t_s1
);

	vec32_t w_nx;
	vec16_t t_nx;

	always_comb begin
		if (SCATTER) begin
			w_nx = level_bfly(w_in, t_in, LVL);
			t_nx = t_in;
		end else begin
			w_nx = w_in;
			t_nx = level_tmp(w_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1 <= w_nx;
			t_s1 <= t_nx;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/c128_round.sv
// ----------------------------------------------------------------------------
// c128_round
// One scramble round: five levels as ten stages, permutation on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module c128_round
	import c128_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   vld_in,
	input  wire vec16_t st_in,
	input  wire vec16_t mix_in,
	output logic        vld_out,
	output vec16_t      st_out,
	output vec16_t      mix_out
);

	localparam int NStg = 2 * NumLevels;

	logic   vld [NStg+1];
	vec32_t w   [NStg+1];
	vec16_t t   [NStg+1];

	assign vld[0] = vld_in;
	assign w[0]   = {mix_in, st_in};
	assign t[0]   = '0;

	for (genvar g = 0; g < NStg; g++) begin : g_stg
		c128_half #(.LVL(g / 2), .SCATTER(g % 2 == 1)) u_half (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (vld[g]),
			.w_in   (w[g]),
			.t_in   (t[g]),
			.vld_s1 (vld[g+1]),
			.w_s1   (w[g+1]),
			.t_s1   (t[g+1])
		);
	end

	// the butterfly overwrites the upper half, so the key mix travels alongside
	vec16_t mix_q [NStg];
	always_ff @(posedge clk) begin
		if (en) begin
			mix_q[0] <= mix_in;
			for (int i = 1; i < NStg; i++) begin
				mix_q[i] <= mix_q[i-1];
			end
		end
	end

	assign vld_out = vld[NStg];
	assign st_out  = perm(w[NStg]);
	assign mix_out = mix_q[NStg-1];

endmodule

`default_nettype wire

FILE: tb/tb_comp128_v3_auth_hash_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_comp128_v3_auth_hash_top
// Self-checking bench for the keyed auth hash: challenges go in over the
// request channel and each result word is checked against a local hash model.
// The key is changed over APB between phases, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_comp128_v3_auth_hash_top;
	import c128_pkg::*;

	typedef struct packed {
		logic [31:0] sres;
		logic [63:0] kc;
	} auth_res_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	c128_chal_if chal ();
	c128_resp_if resp ();

	comp128_v3_auth_hash_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.chal    (chal.sink),
		.resp    (resp.source)
	);

	logic [63:0] key_hi;
	logic [63:0] key_lo;
	auth_res_t   auth_q[$];
	int          errors;
	int          words_sent;
	int          words_checked;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_req;
	int          hold_left;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// local model of the hash
	function automatic auth_res_t comp128_hash(input logic [63:0] kh, input logic [63:0] kl,
			input logic [63:0] rh, input logic [63:0] rl);
		logic [7:0] keyb[16];
		logic [7:0] chb[16];
		logic [7:0] st[16];
		logic [7:0] mx[16];
		logic [7:0] w[32];
		logic [7:0] t[16];
		logic [7:0] v;
		logic [63:0] kc;
		logic [31:0] sres;
		int src;
		int hi;
		int lo;
		int pos;
		int sh;
		auth_res_t r;
		for (int n = 0; n < 8; n++) begin
			keyb[n]   = kh[63-8*n -: 8];
			keyb[8+n] = kl[63-8*n -: 8];
			chb[n]    = rh[63-8*n -: 8];
			chb[8+n]  = rl[63-8*n -: 8];
		end
		for (int n = 0; n < 16; n++) begin
			st[n] = chb[15-n];
			mx[n] = keyb[15-n] ^ chb[15-n];
		end
		for (int rnd = 0; rnd < 8; rnd++) begin
			for (int n = 0; n < 16; n++) begin
				w[n]    = st[n];
				w[16+n] = mx[n];
			end
			for (int lvl = 0; lvl < 5; lvl++) begin
				for (int z = 0; z < 16; z++)
					t[z] = SBOX_A[SBOX_B[w[z+16]] ^ w[z]];
				for (int j = 0; j < (1 << lvl); j++) begin
					for (int k = 0; k < (1 << (4 - lvl)); k++) begin
						src = ((k << lvl) + j) & 15;
						hi  = ((((2 * k) + 1) << lvl) + j) & 31;
						lo  = ((k << (lvl + 1)) + j) & 31;
						w[hi] = SBOX_A[SBOX_B[t[src]] ^ w[(src + 16) & 31]];
						w[lo] = t[src];
					end
				end
			end
			for (int i = 0; i < 16; i++) begin
				v = 8'h00;
				for (int j = 0; j < 8; j++) begin
					pos  = ((19 * (j + 8 * i) + 19) & 255) / 8;
					sh   = (3 * j + 3) & 7;
					v[j] = w[pos][sh];
				end
				st[i] = v;
			end
		end
		// result bytes are the state taken in reverse
		sres = {st[15], st[14], st[13], st[12]};
		kc   = {st[7], st[6], st[5], st[4], st[3], st[2], st[1], st[0]};
		r.sres = sres;
		r.kc   = kc;
		return r;
	endfunction

	task automatic apb_write(input reg_idx_t idx, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx) << 3;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_KEY_HIGH)
			key_hi = data;
		else
			key_lo = data;
	endtask

	task automatic set_key(input logic [63:0] kh, input logic [63:0] kl);
		apb_write(REG_KEY_HIGH, kh);
		apb_write(REG_KEY_LOW, kl);
	endtask

	// leaves valid high on return so back-to-back words need no toggle
	task automatic send_chal(input logic [63:0] rh, input logic [63:0] rl);
		while ($urandom_range(99) < send_idle_pct) begin
			chal.valid <= 1'b0;
			@(posedge clk);
		end
		chal.valid     <= 1'b1;
		chal.rand_high <= rh;
		chal.rand_low  <= rl;
		@(posedge clk);
		while (!chal.ready)
			@(posedge clk);
		auth_q.push_back(comp128_hash(key_hi, key_lo, rh, rl));
		words_sent++;
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		chal.valid <= 1'b0;
		while (auth_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		// pipeline depth plus margin
		repeat (100) @(posedge clk);
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_chal({$urandom, $urandom}, {$urandom, $urandom});
	endtask

	always @(posedge clk or negedge arst_n) begin
		auth_res_t exp_res;
		if (!arst_n) begin
			resp.ready <= 1'b0;
			hold_left  = 0;
		end else begin
			if (resp.valid && resp.ready) begin
				if (auth_q.size() == 0) begin
					$display("%0t: unexpected word sres=%h kc=%h", $time, resp.sres, resp.kc);
					errors++;
				end else begin
					exp_res = auth_q.pop_front();
					words_checked++;
					if (resp.sres !== exp_res.sres) begin
						$display("%0t: sres mismatch expected %h actual %h",
							$time, exp_res.sres, resp.sres);
						errors++;
					end
					if (resp.kc !== exp_res.kc) begin
						$display("%0t: kc mismatch expected %h actual %h",
							$time, exp_res.kc, resp.kc);
						errors++;
					end
				end
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				resp.ready <= 1'b0;
			end else begin
				resp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic test_directed;
		// zero key, extreme and walking challenges
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_chal('0, '0);
		send_chal('1, '1);
		send_chal('1, '0);
		send_chal('0, '1);
		send_chal(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_chal(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
		for (int b = 0; b < 8; b++)
			send_chal(64'h1 << (8 * b + b), 64'h8000_0000_0000_0000 >> (8 * b + b));
		drain();
		set_key('1, '1);
		send_chal('0, '0);
		send_chal('1, '1);
		send_chal(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		drain();
		set_key('1, '0);
		send_chal('0, '0);
		send_chal('1, '1);
		drain();
		set_key('0, '1);
		send_chal('0, '0);
		send_chal('1, '1);
		// challenge equal to the key gives an all-zero mix
		send_chal('0, '1);
		drain();
	endtask

	task automatic test_random_idle(input int s_pct, input int r_pct, input int n);
		set_key({$urandom, $urandom}, {$urandom, $urandom});
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		send_random(n);
		drain();
	endtask

	task automatic test_backpressure;
		set_key({$urandom, $urandom}, {$urandom, $urandom});
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_req = 300;
		send_random(150);
		// let everything out before the next burst
		chal.valid <= 1'b0;
		while (auth_q.size() != 0)
			@(posedge clk);
		recv_stall_pct = 27;
		send_random(40);
		drain();
	endtask

	initial begin
		errors         = 0;
		words_sent     = 0;
		words_checked  = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 0;
		key_hi         = '0;
		key_lo         = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		chal.valid     = 1'b0;
		chal.rand_high = '0;
		chal.rand_low  = '0;
		arst_n         = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_idle(0, 0, 350);
		test_random_idle(63, 0, 350);
		test_random_idle(0, 63, 350);
		test_random_idle(27, 27, 350);
		test_backpressure();
		$display("covered %0d challenges, %0d results checked, under key changes,",
			words_sent, words_checked);
		$display("random idling on both sides and a long output hold-off");
		if (errors == 0 && auth_q.size() == 0) begin
			$display("[comp128_v3_auth_hash_top] OK");
		end else begin
			$display("%0t: %0d words still expected, %0d errors", $time, auth_q.size(), errors);
			$display("[comp128_v3_auth_hash_top] ERROR");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("%0t: timeout", $time);
		$display("[comp128_v3_auth_hash_top] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
rtl/c128_pkg.sv
rtl/c128_if.sv
rtl/c128_half.sv
rtl/c128_round.sv
rtl/comp128_v3_auth_hash_top.sv
tb/tb_comp128_v3_auth_hash_top.sv
